### rtl/fbd_pkg.sv
// Shared widths, constants and divider request/response types for the
// fractional baud divider search. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fbd_pkg;

  localparam int CLK_W   = 27;
  localparam int BAUD_W  = 23;
  localparam int DL_W    = 16;
  localparam int FR_W    = 4;
  localparam int SUM_W   = FR_W + 1;
  localparam int DIV_W   = 32;
  localparam int CNT_W   = $clog2(DIV_W);

  localparam logic [FR_W-1:0]  MUL_MAX   = 4'd15;
  localparam logic [DL_W-1:0]  DIV_MAX   = 16'hFFFF;
  localparam logic [CLK_W-1:0] CLK_RESET = 27'd100000000;

  // request into the shared serial divider
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  // divider result; quo and rem hold until the next start
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

### rtl/fbd_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on fbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fbd_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fbd_pkg::div_req_t req,
  output fbd_pkg::div_rsp_t      rsp
);
  import fbd_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] den;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   trial;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    rem_sh = {rem, quo[DIV_W-1]};
    trial  = rem_sh - {1'b0, den};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      if (!trial[DIV_W]) begin
        rem <= trial[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule
`default_nettype wire

### rtl/fractional_baud_divider_search_top.sv
// Top level of the fractional baud divider search: sequencer, candidate
// evaluation and output register. Depends on fbd_pkg and fbd_divider.
//
// channel  dir  width  content
// s_axis   in   24     baud_rate[22:0]
// m_axis   out  24     divisor[15:0], mul_val[19:16], div_add_val[23:20]
// cfg      in   27     clock_hz, write-only
//
// One request at a time. The shared serial divider sets the rate: the plain
// quotient first, then two divides per (mul, divadd) pair for up to all 120
// pairs; an exact plain divide or a zero-error pair ends sooner. Zero baud
// skips the divider. Reset is synchronous and restores clock_hz to 100 MHz.
// A stalled result holds in the output register; the next request is taken
// once the sequencer is idle.
`timescale 1ns / 1ps
`default_nettype none
module fractional_baud_divider_search_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // baud_rate[22:0], zero pad [23]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // divisor[15:0], mul_val[19:16],
                                          // div_add_val[23:20]
  input  wire logic        cfg_we,
  input  wire logic [26:0] cfg_wdata
);
  import fbd_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE       = 9'b000000001,
    ST_PLAIN_GO   = 9'b000000010,
    ST_PLAIN_WAIT = 9'b000000100,
    ST_CAND_GO    = 9'b000001000,
    ST_Q_WAIT     = 9'b000010000,
    ST_ACH_GO     = 9'b000100000,
    ST_ACH_WAIT   = 9'b001000000,
    ST_EVAL       = 9'b010000000,
    ST_EMIT       = 9'b100000000
  } state_t;

  state_t            state;
  logic [CLK_W-1:0]  clock_hz;
  logic [BAUD_W-1:0] baud;
  logic [FR_W-1:0]   cur_m;
  logic [FR_W-1:0]   cur_a;
  logic [DL_W-1:0]   cand;
  logic [DL_W-1:0]   best_dl;
  logic [FR_W-1:0]   best_m;
  logic [FR_W-1:0]   best_a;
  logic [DIV_W-1:0]  best_err;
  logic [DL_W-1:0]   out_dl;
  logic [FR_W-1:0]   out_m;
  logic [FR_W-1:0]   out_a;
  logic              out_valid;

  div_req_t          dreq;
  div_rsp_t          drsp;

  logic [SUM_W-1:0]  sum_ma;
  logic [DIV_W-1:0]  num_mc;
  logic [DIV_W:0]    q_inc;
  logic [DIV_W-1:0]  q_half;
  logic [DL_W-1:0]   cand_next;
  logic [DIV_W-1:0]  ach;
  logic [DIV_W-1:0]  baud_ext;
  logic [DIV_W-1:0]  err;
  logic              out_free;

  // clock register
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= CLK_RESET;
    end else if (cfg_we) begin
      clock_hz <= cfg_wdata;
    end
  end

  // operands for the divider; the divider's input registers follow the products
  always_comb begin
    sum_ma   = SUM_W'(cur_m) + SUM_W'(cur_a);
    num_mc   = DIV_W'(cur_m) * DIV_W'(clock_hz);
    baud_ext = DIV_W'(baud);
    dreq     = '0;
    unique case (state)
      ST_PLAIN_GO: begin
        dreq.start = 1'b1;
        dreq.num   = DIV_W'(clock_hz);
        dreq.den   = baud_ext << 4;
      end
      ST_CAND_GO: begin
        dreq.start = 1'b1;
        dreq.num   = num_mc;
        dreq.den   = (baud_ext * DIV_W'(sum_ma)) << 3;
      end
      ST_ACH_GO: begin
        dreq.start = 1'b1;
        dreq.num   = num_mc;
        dreq.den   = (DIV_W'(cand) * DIV_W'(sum_ma)) << 3;
      end
      default: dreq = '0;
    endcase
  end

  fbd_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // rounded half of the quotient, shared by the divisor and achieved-rate paths
  always_comb begin
    q_inc  = {1'b0, drsp.quo} + 1'b1;
    q_half = q_inc[DIV_W:1];
    ach    = q_half;
    err    = (ach > baud_ext) ? (ach - baud_ext) : (baud_ext - ach);
    if (q_half > DIV_W'(DIV_MAX)) begin
      cand_next = DIV_MAX;
    end else begin
      cand_next = q_half[DL_W-1:0];
    end
    if (cand_next == '0) begin
      cand_next = DL_W'(1);
    end
    if (cur_a != '0 && cand_next < DL_W'(2)) begin
      cand_next = DL_W'(2);
    end
  end

  assign out_free = !out_valid || m_axis_tready;

  // result valid: set on emit, cleared when the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tvalid && m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            baud <= s_axis_tdata[BAUD_W-1:0];
            if (s_axis_tdata[BAUD_W-1:0] == '0) begin
              best_dl <= DIV_MAX;
              best_m  <= FR_W'(1);
              best_a  <= '0;
              state   <= ST_EMIT;
            end else begin
              state <= ST_PLAIN_GO;
            end
          end
        end
        ST_PLAIN_GO: state <= ST_PLAIN_WAIT;
        ST_PLAIN_WAIT: begin
          if (drsp.done) begin
            best_dl  <= (drsp.quo > DIV_W'(DIV_MAX)) ? DIV_MAX : drsp.quo[DL_W-1:0];
            best_m   <= FR_W'(1);
            best_a   <= '0;
            best_err <= baud_ext;
            cur_m    <= FR_W'(1);
            cur_a    <= '0;
            state    <= (drsp.rem == '0) ? ST_EMIT : ST_CAND_GO;
          end
        end
        ST_CAND_GO: state <= ST_Q_WAIT;
        ST_Q_WAIT: begin
          if (drsp.done) begin
            cand  <= cand_next;
            state <= ST_ACH_GO;
          end
        end
        ST_ACH_GO: state <= ST_ACH_WAIT;
        ST_ACH_WAIT: begin
          if (drsp.done) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          // keep the first pair that strictly lowers the error
          if (err < best_err) begin
            best_err <= err;
            best_dl  <= cand;
            best_m   <= cur_m;
            best_a   <= cur_a;
          end
          if ((err < best_err && err == '0) ||
              (cur_m == MUL_MAX && cur_a == MUL_MAX - 1'b1)) begin
            state <= ST_EMIT;
          end else begin
            if (cur_a == cur_m - 1'b1) begin
              cur_m <= cur_m + 1'b1;
              cur_a <= '0;
            end else begin
              cur_a <= cur_a + 1'b1;
            end
            state <= ST_CAND_GO;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_dl <= (best_dl == '0) ? DL_W'(1) : best_dl;
            out_m  <= best_m;
            out_a  <= best_a;
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_a, out_m, out_dl};

  // checks
  a_frac_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[23:20] < m_axis_tdata[19:16]))
    else $error("div_add_val not below mul_val");

  a_dl_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[15:0] != '0))
    else $error("zero divisor emitted");

  a_pair_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) |-> (cur_m != '0 && cur_a < cur_m))
    else $error("candidate pair out of range");

endmodule
`default_nettype wire
